[design/priority_deque_with_keyed_removal_top_macros.svh]
// Assertion macros shared by the deque RTL.
`ifndef PRIORITY_DEQUE_WITH_KEYED_REMOVAL_TOP_MACROS_SVH
`define PRIORITY_DEQUE_WITH_KEYED_REMOVAL_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PDQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define PDQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/pdq_pkg.sv]
// Types, codes and the key folding function for the keyed-removal deque.
`default_nettype none

package pdq_pkg;

  // Command codes carried in the func field.
  typedef enum logic [1:0] {
    FN_PUSH_TAIL = 2'd0,
    FN_PUSH_HEAD = 2'd1,
    FN_POP_HEAD  = 2'd2,
    FN_REMOVE    = 2'd3
  } func_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SEARCH,
    S_SHIFT,
    S_RESP
  } state_t;

  // One command beat.
  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] entry_key;
    logic [31:0] entry_payload;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] out_key;
    logic [31:0] out_payload;
    logic [7:0]  occupancy;
  } rsp_t;

  // One stored queue entry.
  typedef struct packed {
    logic [63:0] key;
    logic [31:0] payload;
  } entry_t;

  // Fold ASCII upper-case letters to lower case in each of the eight bytes.
  function automatic logic [63:0] fold_key(input logic [63:0] k);
    logic [63:0] r;
    logic [7:0]  c;
    for (int b = 0; b < 8; b++) begin
      c = k[8*b +: 8];
      if (c >= 8'h41 && c <= 8'h5A) begin
        c = c + 8'h20;
      end
      r[8*b +: 8] = c;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/pdq_match.sv]
// Case-insensitive key comparator shared by every step of the keyed search.
`default_nettype none

module pdq_match (
  input  logic [63:0] stored_key,
  input  logic [63:0] want_key,
  output logic        hit
);
  import pdq_pkg::*;

  // The wanted key arrives already folded.
  assign hit = (fold_key(stored_key) == want_key);

endmodule

`default_nettype wire

[design/priority_deque_with_keyed_removal_top.sv]
// Bounded deque with keyed removal: circular entry memory under a small sequencer.
// Pushes, and any command that finds the queue full or empty, go straight to the result state;
// pop reads the head entry first. Keyed removal searches from the head over the single read
// port until a match, then compaction moves each later entry forward by one place.
// One command at a time; a finished result waits in the output register.
// Synchronous reset empties the queue; no clearing pass is needed.
`default_nettype none
`include "priority_deque_with_keyed_removal_top_macros.svh"

module priority_deque_with_keyed_removal_top #(
  parameter int QUEUE_DEPTH = 128
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  pdq_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output pdq_pkg::rsp_t rsp
);
  import pdq_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = CW + 1;
  localparam int SW = IW + 1;

  // Map a logical position from the head to a memory address.
  function automatic logic [PW-1:0] phys(input logic [PW-1:0] base,
                                         input logic [IW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  state_t         state, state_next;
  logic [PW-1:0]  head, head_next;
  logic [CW-1:0]  count, count_next;
  logic [63:0]    want, want_next;
  logic [IW-1:0]  scan_idx, scan_idx_next;
  logic           cmp_valid, cmp_valid_next;
  logic [IW-1:0]  cmp_idx, cmp_idx_next;
  logic [IW-1:0]  shf_idx, shf_idx_next;
  logic           wr_pend, wr_pend_next;
  logic [PW-1:0]  wr_phys, wr_phys_next;
  status_t        res_status, res_status_next;
  entry_t         res_entry, res_entry_next;

  entry_t         mem [QUEUE_DEPTH];
  entry_t         rd_data;
  logic [PW-1:0]  rd_addr;
  logic           wr_en;
  logic [PW-1:0]  wr_addr;
  entry_t         wr_data;

  logic           hit;
  logic           load_rsp;
  logic           full;
  logic           push_room;
  logic [PW-1:0]  head_inc;
  logic [PW-1:0]  head_dec;

  // Shared key comparator.
  pdq_match u_match (
    .stored_key (rd_data.key),
    .want_key   (want),
    .hit        (hit)
  );

  assign full     = (count == CW'(QUEUE_DEPTH));
  assign head_inc = (head == PW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? PW'(QUEUE_DEPTH - 1) : head - 1'b1;

  // A push beat accepted while the queue has room.
  assign push_room = cmd_valid && !cmd_stall && !full &&
                     (cmd.func == FN_PUSH_TAIL || cmd.func == FN_PUSH_HEAD);

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Sequencer next state and memory port control.
  always_comb begin
    state_next      = state;
    head_next       = head;
    count_next      = count;
    want_next       = want;
    scan_idx_next   = scan_idx;
    cmp_valid_next  = cmp_valid;
    cmp_idx_next    = cmp_idx;
    shf_idx_next    = shf_idx;
    wr_pend_next    = wr_pend;
    wr_phys_next    = wr_phys;
    res_status_next = res_status;
    res_entry_next  = res_entry;
    rd_addr         = head;
    wr_en           = 1'b0;
    wr_addr         = head;
    wr_data         = '{key: cmd.entry_key, payload: cmd.entry_payload};
    load_rsp        = 1'b0;
    cmd_stall       = (state != S_IDLE);

    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          res_entry_next  = '0;
          res_status_next = ST_OK;
          state_next      = S_RESP;
          case (cmd.func)
            FN_PUSH_TAIL: begin
              if (full) begin
                res_status_next = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = phys(head, IW'(count));
                count_next = count + 1'b1;
              end
            end
            FN_PUSH_HEAD: begin
              if (full) begin
                res_status_next = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = head_dec;
                head_next  = head_dec;
                count_next = count + 1'b1;
              end
            end
            FN_POP_HEAD: begin
              // The head entry is read on this edge.
              if (count == '0) begin
                res_status_next = ST_EMPTY;
              end else begin
                state_next = S_POP;
              end
            end
            default: begin
              want_next = fold_key(cmd.entry_key);
              if (count == '0) begin
                res_status_next = ST_NOT_FOUND;
              end else begin
                scan_idx_next  = IW'(1);
                cmp_valid_next = 1'b1;
                cmp_idx_next   = '0;
                state_next     = S_SEARCH;
              end
            end
          endcase
        end
      end

      S_POP: begin
        res_entry_next = rd_data;
        head_next      = head_inc;
        count_next     = count - 1'b1;
        state_next     = S_RESP;
      end

      // Read one entry per cycle and compare the one read in the cycle before.
      S_SEARCH: begin
        rd_addr = phys(head, scan_idx);
        if (cmp_valid && hit) begin
          res_entry_next = rd_data;
          shf_idx_next   = cmp_idx + 1'b1;
          wr_pend_next   = 1'b0;
          state_next     = S_SHIFT;
        end else if (!cmp_valid) begin
          res_status_next = ST_NOT_FOUND;
          state_next      = S_RESP;
        end else begin
          cmp_valid_next = (scan_idx < IW'(count));
          cmp_idx_next   = scan_idx;
          scan_idx_next  = scan_idx + 1'b1;
        end
      end

      // Move each entry behind the removed one forward by one place.
      S_SHIFT: begin
        rd_addr = phys(head, shf_idx);
        if (wr_pend) begin
          wr_en   = 1'b1;
          wr_addr = wr_phys;
          wr_data = rd_data;
        end
        if (shf_idx < IW'(count)) begin
          wr_pend_next = 1'b1;
          wr_phys_next = phys(head, shf_idx - 1'b1);
          shf_idx_next = shf_idx + 1'b1;
        end else begin
          wr_pend_next = 1'b0;
          count_next   = count - 1'b1;
          state_next   = S_RESP;
        end
      end

      S_RESP: begin
        load_rsp = !rsp_valid || !rsp_stall;
        if (load_rsp) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      cmp_valid <= 1'b0;
      wr_pend   <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      cmp_valid <= cmp_valid_next;
      wr_pend   <= wr_pend_next;
    end
  end

  // Working registers without reset.
  always_ff @(posedge clk) begin
    want       <= want_next;
    scan_idx   <= scan_idx_next;
    cmp_idx    <= cmp_idx_next;
    shf_idx    <= shf_idx_next;
    wr_phys    <= wr_phys_next;
    res_status <= res_status_next;
    res_entry  <= res_entry_next;
  end

  // Result output register; a beat holds until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp <= '{status: res_status, out_key: res_entry.key,
               out_payload: res_entry.payload, occupancy: 8'(count)};
    end
  end

  // The entry count never passes the depth.
  `PDQ_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(QUEUE_DEPTH), "count over depth")
  // An accepted command keeps the block busy in the next cycle.
  `PDQ_ASSERT_NEXT(a_busy_after_accept, clk, rst, cmd_valid && !cmd_stall, cmd_stall, "not busy")
  // A full report only comes from a full queue.
  `PDQ_ASSERT_NOW(a_full_status, clk, rst, load_rsp && res_status == ST_FULL, full, "bad full")
  // A push into a queue with room adds exactly one entry.
  `PDQ_ASSERT_NEXT(a_push_grows, clk, rst, push_room, count == $past(count) + 1'b1, "push count")

endmodule

`default_nettype wire

[tb/tb_priority_deque_with_keyed_removal_top.sv]
// Self-checking testbench for the keyed-removal deque: directed table, then random phases.
`timescale 1ns / 1ps

module tb_priority_deque_with_keyed_removal_top;
  import pdq_pkg::*;

  localparam int DEPTH = 128;

  localparam logic [63:0] K_UPPER = "ABCDEFGH";
  localparam logic [63:0] K_LOWER = "abcdefgh";
  localparam logic [63:0] K_MIXED = "aBcDeFgH";
  localparam logic [63:0] K_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
  // Bytes just outside the letter range plus the two range ends.
  localparam logic [63:0] K_EDGES = 64'h405B_C160_7BE1_415A;
  localparam logic [63:0] K_NEAR  = 64'h607B_E140_5BC1_617A;
  localparam logic [63:0] K_ZLOW  = "zzzzzzzz";
  localparam logic [63:0] K_ZUP   = "ZZZZZZZZ";
  localparam logic [63:0] K_ZMIX  = "zZzZzZzZ";

  typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

  // One row of the directed table; want is used only where fixed is set.
  typedef struct packed {
    cmd_t  c;
    logic  fixed;
    rsp_t  want;
  } row_t;

  logic clk;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Travels with each command beat: whether a typed-in result replaces the prediction.
  logic row_fixed = 1'b0;
  rsp_t row_want = '0;

  entry_t      shadow_entries[$];
  rsp_t        awaited_rsp[$];
  logic [63:0] key_pool[16];
  row_t        dir_rows[$];

  int mismatch_count = 0;
  int beats_checked = 0;
  int ok_count = 0;
  int full_count = 0;
  int empty_count = 0;
  int miss_count = 0;
  int peak_occupancy = 0;
  int random_items = 0;

  rsp_t want_rsp;
  rsp_t got_rsp;

  priority_deque_with_keyed_removal_top #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Lower-case fold of ASCII capitals; every other byte value is kept as is.
  function automatic logic [63:0] lower_ascii(logic [63:0] k);
    logic [63:0] r;
    logic [7:0]  ch;
    for (int b = 0; b < 8; b++) begin
      ch = k[8*b +: 8];
      if (ch >= 8'h41 && ch <= 8'h5A) begin
        ch[5] = 1'b1;
      end
      r[8*b +: 8] = ch;
    end
    return r;
  endfunction

  // Applies one command to the shadow queue and returns the result it should give.
  function automatic rsp_t deque_predict(cmd_t c);
    rsp_t   r;
    entry_t e;
    int     hit;
    r = '0;
    hit = -1;
    e.key = c.entry_key;
    e.payload = c.entry_payload;
    case (func_t'(c.func))
      FN_PUSH_TAIL, FN_PUSH_HEAD: begin
        if (shadow_entries.size() >= DEPTH) begin
          r.status = ST_FULL;
        end else if (func_t'(c.func) == FN_PUSH_TAIL) begin
          shadow_entries.push_back(e);
        end else begin
          shadow_entries.push_front(e);
        end
      end
      FN_POP_HEAD: begin
        if (shadow_entries.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          e = shadow_entries.pop_front();
          r.out_key = e.key;
          r.out_payload = e.payload;
        end
      end
      default: begin
        // Only the first match from the head goes.
        for (int i = 0; i < shadow_entries.size() && hit < 0; i++) begin
          if (lower_ascii(shadow_entries[i].key) == lower_ascii(c.entry_key)) begin
            hit = i;
          end
        end
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          e = shadow_entries[hit];
          shadow_entries.delete(hit);
          r.out_key = e.key;
          r.out_payload = e.payload;
        end
      end
    endcase
    r.occupancy = 8'(shadow_entries.size());
    return r;
  endfunction

  function automatic row_t dir_row(func_t f, logic [63:0] k, logic [31:0] p, logic fixed,
                                   status_t s, logic [63:0] okey, logic [31:0] opay,
                                   logic [7:0] occ);
    row_t r;
    r.c.func = f;
    r.c.entry_key = k;
    r.c.entry_payload = p;
    r.fixed = fixed;
    r.want.status = s;
    r.want.out_key = okey;
    r.want.out_payload = opay;
    r.want.occupancy = occ;
    return r;
  endfunction

  // Mostly keys from a small pool with random letter case, so removals hit and collide.
  function automatic logic [63:0] make_key();
    logic [63:0] k;
    logic [7:0]  ch;
    if ($urandom_range(0, 9) < 3) begin
      return {$urandom, $urandom};
    end
    k = key_pool[$urandom_range(0, 15)];
    for (int b = 0; b < 8; b++) begin
      ch = k[8*b +: 8];
      if (lower_ascii({56'd0, ch}) != {56'd0, ch} || (ch >= 8'h61 && ch <= 8'h7A)) begin
        ch[5] = ch[5] ^ 1'($urandom_range(0, 1));
      end
      k[8*b +: 8] = ch;
    end
    return k;
  endfunction

  // Idle cycles before a command beat: mostly none or few, now and then a long pause.
  function automatic int pick_gap(logic quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet) begin
      return 0;
    end
    if (r < 50) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Drives one command beat and returns at the edge where it is accepted.
  task automatic send(cmd_t c, logic fixed, rsp_t want, int gap);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= c;
    row_fixed <= fixed;
    row_want <= want;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
  endtask

  // One random phase: filling, draining or a balanced mix of commands.
  task automatic run_phase(phase_t kind, int n);
    cmd_t c;
    logic quiet;
    quiet = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      case (kind)
        PH_FILL: c.func = ($urandom_range(0, 3) == 0) ? FN_PUSH_HEAD : FN_PUSH_TAIL;
        PH_DRAIN: c.func = ($urandom_range(0, 99) < 55) ? FN_POP_HEAD : FN_REMOVE;
        default: c.func = func_t'($urandom_range(0, 3));
      endcase
      c.entry_key = make_key();
      c.entry_payload = $urandom;
      send(c, 1'b0, '0, pick_gap(quiet));
      random_items++;
    end
  endtask

  // Result side stalls in bursts, with long stretches of no stall now and then.
  initial begin
    forever begin
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12))
        @(posedge clk);
      rsp_stall <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4))
        @(posedge clk);
      rsp_stall <= 1'b0;
    end
  end

  // Checks each result beat against the oldest expectation, then predicts accepted commands.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        got_rsp = rsp;
        if (awaited_rsp.size() == 0) begin
          $error("result beat with no command waiting: status %0d key %h payload %h occ %0d",
                 got_rsp.status, got_rsp.out_key, got_rsp.out_payload, got_rsp.occupancy);
          mismatch_count++;
        end else begin
          want_rsp = awaited_rsp.pop_front();
          beats_checked++;
          if (got_rsp.status != want_rsp.status) begin
            $error("status: expected %0d, got %0d", want_rsp.status, got_rsp.status);
            mismatch_count++;
          end
          if (got_rsp.out_key != want_rsp.out_key) begin
            $error("out_key: expected %h, got %h", want_rsp.out_key, got_rsp.out_key);
            mismatch_count++;
          end
          if (got_rsp.out_payload != want_rsp.out_payload) begin
            $error("out_payload: expected %h, got %h", want_rsp.out_payload,
                   got_rsp.out_payload);
            mismatch_count++;
          end
          if (got_rsp.occupancy != want_rsp.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want_rsp.occupancy, got_rsp.occupancy);
            mismatch_count++;
          end
          case (status_t'(want_rsp.status))
            ST_OK: ok_count++;
            ST_FULL: full_count++;
            ST_EMPTY: empty_count++;
            default: miss_count++;
          endcase
          if (int'(want_rsp.occupancy) > peak_occupancy) begin
            peak_occupancy = int'(want_rsp.occupancy);
          end
        end
      end
      if (cmd_valid && !cmd_stall) begin
        want_rsp = deque_predict(cmd);
        awaited_rsp.push_back(row_fixed ? row_want : want_rsp);
      end
    end
  end

  // Stimulus: reset, directed table, random phases, then drain and report.
  initial begin
    for (int i = 0; i < 16; i++) begin
      for (int b = 0; b < 8; b++) begin
        if ($urandom_range(0, 9) < 7) begin
          key_pool[i][8*b +: 8] = 8'($urandom_range(0, 25)) + (($urandom_range(0, 1) == 1)
                                  ? 8'h41 : 8'h61);
        end else begin
          key_pool[i][8*b +: 8] = 8'($urandom_range(0, 255));
        end
      end
    end

    dir_rows = '{
      dir_row(FN_POP_HEAD,  K_UPPER, 32'h0,         1'b1, ST_EMPTY,     64'h0,   32'h0, 8'd0),
      dir_row(FN_REMOVE,    K_LOWER, 32'h0,         1'b1, ST_NOT_FOUND, 64'h0,   32'h0, 8'd0),
      dir_row(FN_PUSH_TAIL, K_ONES,  32'hFFFF_FFFF, 1'b1, ST_OK,        64'h0,   32'h0, 8'd1),
      dir_row(FN_PUSH_TAIL, 64'h0,   32'h0,         1'b1, ST_OK,        64'h0,   32'h0, 8'd2),
      dir_row(FN_PUSH_HEAD, K_UPPER, 32'h1234_5678, 1'b1, ST_OK,        64'h0,   32'h0, 8'd3),
      dir_row(FN_PUSH_TAIL, K_LOWER, 32'hA5A5_A5A5, 1'b1, ST_OK,        64'h0,   32'h0, 8'd4),
      dir_row(FN_REMOVE,    K_MIXED, 32'h0, 1'b1, ST_OK, K_UPPER, 32'h1234_5678, 8'd3),
      dir_row(FN_REMOVE,    K_UPPER, 32'h0, 1'b1, ST_OK, K_LOWER, 32'hA5A5_A5A5, 8'd2),
      dir_row(FN_PUSH_TAIL, K_EDGES, 32'h5A5A_5A5A, 1'b1, ST_OK,        64'h0,   32'h0, 8'd3),
      dir_row(FN_REMOVE,    K_NEAR,  32'h0,         1'b1, ST_NOT_FOUND, 64'h0,   32'h0, 8'd3),
      dir_row(FN_REMOVE,    64'h0,   32'hFFFF_FFFF, 1'b1, ST_OK,        64'h0,   32'h0, 8'd2),
      dir_row(FN_PUSH_HEAD, 64'h8000_0000_0000_0001, 32'h8000_0000, 1'b0, ST_OK,
              64'h0, 32'h0, 8'd0),
      dir_row(FN_POP_HEAD,  64'h0,   32'h0,         1'b0, ST_OK,        64'h0,   32'h0, 8'd0),
      dir_row(FN_REMOVE,    K_EDGES, 32'h0,         1'b0, ST_OK,        64'h0,   32'h0, 8'd0),
      dir_row(FN_PUSH_TAIL, K_ZLOW,  32'h0000_0001, 1'b0, ST_OK,        64'h0,   32'h0, 8'd0),
      dir_row(FN_PUSH_TAIL, K_ZUP,   32'h0000_0002, 1'b0, ST_OK,        64'h0,   32'h0, 8'd0),
      dir_row(FN_REMOVE,    K_ZMIX,  32'h0,         1'b0, ST_OK,        64'h0,   32'h0, 8'd0),
      dir_row(FN_POP_HEAD,  64'h0,   32'h0,         1'b0, ST_OK,        64'h0,   32'h0, 8'd0),
      dir_row(FN_POP_HEAD,  64'h0,   32'h0,         1'b0, ST_OK,        64'h0,   32'h0, 8'd0),
      dir_row(FN_POP_HEAD,  K_ONES,  32'h0,         1'b1, ST_EMPTY,     64'h0,   32'h0, 8'd0)
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send(dir_rows[i].c, dir_rows[i].fixed, dir_rows[i].want, pick_gap(1'b0));
    end

    // Start by filling past full and draining past empty, then wander at random.
    run_phase(PH_FILL, $urandom_range(130, 136));
    run_phase(PH_DRAIN, $urandom_range(130, 136));
    while (random_items < 1100) begin
      case ($urandom_range(0, 5))
        0: run_phase(PH_FILL, $urandom_range(130, 136));
        1: run_phase(PH_DRAIN, $urandom_range(130, 136));
        default: run_phase(PH_MIXED, $urandom_range(40, 80));
      endcase
    end
    cmd_valid <= 1'b0;

    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Checked %0d result beats: %0d ok, %0d full, %0d empty, %0d key not found.",
             beats_checked, ok_count, full_count, empty_count, miss_count);
    $display("Peak occupancy %0d of %0d, %0d random commands after the directed table.",
             peak_occupancy, DEPTH, random_items);
    if (mismatch_count == 0 && awaited_rsp.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
